[hdl/quadratic_root_solver_defines.svh]
// Assertion macros used by the quadratic root solver top level
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/qrs_pkg.sv]
// Shared constants and types of the quadratic root solver
`timescale 1ns / 1ps
package qrs_pkg;
	localparam int COEF_WIDTH_DEF    = 16;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int OUT_WIDTH         = 35;

	typedef enum logic [1:0] {
		KIND_DISTINCT = 2'd0,
		KIND_REPEATED = 2'd1,
		KIND_COMPLEX  = 2'd2,
		KIND_INVALID  = 2'd3
	} kind_t;
endpackage

[hdl/qrs_sqrt.sv]
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module qrs_sqrt #(
	parameter int XW     = 65,
	parameter int RW     = 33,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              src_valid,
	input  logic [XW-1:0]     radicand,
	input  logic [SIDE_W-1:0] src_side,
	output logic              res_valid,
	output logic [RW-1:0]     res_root,
	output logic [SIDE_W-1:0] res_side
);
	localparam int PW  = 2 * RW;
	localparam int RMW = RW + 2;

	logic [PW-1:0]     x_s    [1:RW];
	logic [RW-1:0]     r_s    [1:RW];
	logic [RMW-1:0]    m_s    [1:RW];
	logic [SIDE_W-1:0] side_s [1:RW];
	logic              v_s    [1:RW];

	for (genvar gi = 0; gi < RW; gi++) begin : g_st
		logic [PW-1:0]     xp;
		logic [RW-1:0]     rp;
		logic [RMW-1:0]    mp;
		logic [SIDE_W-1:0] sp;
		logic              vp;
		logic [RMW-1:0]    rem2;
		logic [RMW-1:0]    trial;
		logic              ge;

		if (gi == 0) begin : g_first
			assign xp = PW'(radicand);
			assign rp = '0;
			assign mp = '0;
			assign sp = src_side;
			assign vp = src_valid;
		end else begin : g_next
			assign xp = x_s[gi];
			assign rp = r_s[gi];
			assign mp = m_s[gi];
			assign sp = side_s[gi];
			assign vp = v_s[gi];
		end

		assign rem2  = {mp[RMW-3:0], xp[PW-1:PW-2]};
		assign trial = {rp, 2'b01};
		assign ge    = rem2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[gi+1] <= 1'b0;
			end else if (en) begin
				v_s[gi+1] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[gi+1]    <= {xp[PW-3:0], 2'b00};
				r_s[gi+1]    <= {rp[RW-2:0], ge};
				m_s[gi+1]    <= ge ? rem2 - trial : rem2;
				side_s[gi+1] <= sp;
			end
		end
	end

	assign res_valid = v_s[RW];
	assign res_root  = r_s[RW];
	assign res_side  = side_s[RW];
endmodule

[hdl/qrs_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module qrs_div #(
	parameter int NW     = 34,
	parameter int DW     = 17,
	parameter int SIDE_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              src_valid,
	input  logic [NW-1:0]     src_num,
	input  logic [DW-1:0]     src_den,
	input  logic [SIDE_W-1:0] src_side,
	output logic              res_valid,
	output logic [NW-1:0]     res_quot,
	output logic [SIDE_W-1:0] res_side
);
	logic [NW-1:0]     n_s    [1:NW];
	logic [DW-1:0]     d_s    [1:NW];
	logic [DW-1:0]     m_s    [1:NW];
	logic [SIDE_W-1:0] side_s [1:NW];
	logic              v_s    [1:NW];

	for (genvar gi = 0; gi < NW; gi++) begin : g_st
		logic [NW-1:0]     np;
		logic [DW-1:0]     dp;
		logic [DW-1:0]     mp;
		logic [SIDE_W-1:0] sp;
		logic              vp;
		logic [DW:0]       rem2;
		logic [DW:0]       diff;
		logic              ge;

		if (gi == 0) begin : g_first
			assign np = src_num;
			assign dp = src_den;
			assign mp = '0;
			assign sp = src_side;
			assign vp = src_valid;
		end else begin : g_next
			assign np = n_s[gi];
			assign dp = d_s[gi];
			assign mp = m_s[gi];
			assign sp = side_s[gi];
			assign vp = v_s[gi];
		end

		assign rem2 = {mp, np[NW-1]};
		assign diff = rem2 - {1'b0, dp};
		assign ge   = rem2 >= {1'b0, dp};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[gi+1] <= 1'b0;
			end else if (en) begin
				v_s[gi+1] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[gi+1]    <= {np[NW-2:0], ge};
				d_s[gi+1]    <= dp;
				m_s[gi+1]    <= ge ? diff[DW-1:0] : rem2[DW-1:0];
				side_s[gi+1] <= sp;
			end
		end
	end

	assign res_valid = v_s[NW];
	assign res_quot  = n_s[NW];
	assign res_side  = side_s[NW];
endmodule

[hdl/quadratic_root_solver.sv]
// Top level of the pipelined quadratic root solver
`timescale 1ns / 1ps
`include "quadratic_root_solver_defines.svh"
// Solves a*x^2 + b*x + c from one coefficient transaction per cycle. The exact
// discriminant is formed in two stages, its scaled square root in RW stages
// (one bit each), the numerators in one stage, both quotients in NW stages of
// two parallel dividers, and the signed, saturated result in one last stage.
// Here XW = 2*COEF_WIDTH + 1 + 2*FRACTION_BITS, RW = ceil(XW/2) and
// NW = max(COEF_WIDTH + FRACTION_BITS, RW) + 1 (33 and 34 at the defaults).
// Throughput is one transaction per cycle; while a result is held by out_stall
// the whole pipeline holds and in_stall is raised.
module quadratic_root_solver #(
	parameter int COEF_WIDTH    = qrs_pkg::COEF_WIDTH_DEF,
	parameter int FRACTION_BITS = qrs_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COEF_WIDTH-1:0]        coef_a,
	input  logic signed [COEF_WIDTH-1:0]        coef_b,
	input  logic signed [COEF_WIDTH-1:0]        coef_c,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          root_kind,
	output logic signed [qrs_pkg::OUT_WIDTH-1:0] first_value,
	output logic signed [qrs_pkg::OUT_WIDTH-1:0] second_value
);
	import qrs_pkg::*;

	localparam int W      = COEF_WIDTH;
	localparam int F      = FRACTION_BITS;
	localparam int DW     = 2 * W + 1;
	localparam int XW     = DW + 2 * F;
	localparam int RW     = (XW + 1) / 2;
	localparam int NW     = ((W + F > RW) ? W + F : RW) + 1;
	localparam int NSW    = NW + 1;
	localparam int SIDE_S = 2 + 1 + W + W;
	localparam int VW     = (NSW > OUT_WIDTH) ? NSW : OUT_WIDTH;

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic [W-1:0] amag_c, bmag_c, cmag_c;
	assign amag_c = coef_a[W-1] ? W'(-coef_a) : W'(coef_a);
	assign bmag_c = coef_b[W-1] ? W'(-coef_b) : W'(coef_b);
	assign cmag_c = coef_c[W-1] ? W'(-coef_c) : W'(coef_c);

	logic                v_s1;
	logic signed [W-1:0] a_s1, b_s1, c_s1;
	logic [2*W-1:0]      bb_s1, ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_a;
			b_s1  <= coef_b;
			c_s1  <= coef_c;
			bb_s1 <= (2*W)'(bmag_c) * (2*W)'(bmag_c);
			ac_s1 <= (2*W)'(amag_c) * (2*W)'(cmag_c);
		end
	end

	logic [DW-1:0] bbx, ac4;
	logic          opp;
	logic [DW-1:0] md_c;
	kind_t         kind_c;
	assign bbx = DW'(bb_s1);
	assign ac4 = DW'(ac_s1) << 2;
	assign opp = (a_s1[W-1] != c_s1[W-1]) && (c_s1 != '0);

	always_comb begin
		md_c   = bbx - ac4;
		kind_c = KIND_DISTINCT;
		if (a_s1 == '0) begin
			kind_c = KIND_INVALID;
		end else if (opp) begin
			md_c = bbx + ac4;
		end else if (bbx == ac4) begin
			kind_c = KIND_REPEATED;
		end else if (bbx < ac4) begin
			md_c   = ac4 - bbx;
			kind_c = KIND_COMPLEX;
		end
	end

	logic                v_s2;
	logic [DW-1:0]       md_s2;
	kind_t               kind_s2;
	logic                aneg_s2;
	logic [W-1:0]        amag_s2;
	logic signed [W-1:0] b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			md_s2   <= md_c;
			kind_s2 <= kind_c;
			aneg_s2 <= a_s1[W-1];
			amag_s2 <= a_s1[W-1] ? W'(-a_s1) : W'(a_s1);
			b_s2    <= b_s1;
		end
	end

	logic              v_sq;
	logic [RW-1:0]     root_sq;
	logic [SIDE_S-1:0] side_sq;

	qrs_sqrt #(.XW(XW), .RW(RW), .SIDE_W(SIDE_S)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (v_s2),
		.radicand  ({md_s2, {(2*F){1'b0}}}),
		.src_side  ({kind_s2, aneg_s2, amag_s2, b_s2}),
		.res_valid (v_sq),
		.res_root  (root_sq),
		.res_side  (side_sq)
	);

	kind_t               kind_sq;
	logic                aneg_sq;
	logic [W-1:0]        amag_sq;
	logic signed [W-1:0] b_sq;
	assign kind_sq = kind_t'(side_sq[SIDE_S-1 -: 2]);
	assign aneg_sq = side_sq[2*W];
	assign amag_sq = side_sq[2*W-1:W];
	assign b_sq    = side_sq[W-1:0];

	logic signed [NSW-1:0] nb_c, sv_c, n1_c, n2_c;
	assign nb_c = -(NSW'(b_sq) <<< F);
	assign sv_c = signed'(NSW'(root_sq));

	always_comb begin
		n1_c = nb_c;
		n2_c = nb_c;
		case (kind_sq)
			KIND_DISTINCT: begin
				n1_c = nb_c + sv_c;
				n2_c = nb_c - sv_c;
			end
			KIND_COMPLEX: n2_c = sv_c;
			default: n2_c = nb_c;
		endcase
	end

	logic          v_s3;
	logic [NW-1:0] n1m_s3, n2m_s3;
	logic          neg1_s3, neg2_s3;
	kind_t         kind_s3;
	logic [W:0]    den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1m_s3  <= n1_c[NSW-1] ? NW'(-n1_c) : NW'(n1_c);
			n2m_s3  <= n2_c[NSW-1] ? NW'(-n2_c) : NW'(n2_c);
			neg1_s3 <= n1_c[NSW-1] ^ aneg_sq;
			neg2_s3 <= n2_c[NSW-1] ^ aneg_sq;
			kind_s3 <= kind_sq;
			den_s3  <= {amag_sq, 1'b0};
		end
	end

	logic          v_d1, v_d2;
	logic [NW-1:0] q1, q2;
	logic [2:0]    side_d1;
	logic          side_d2;

	qrs_div #(.NW(NW), .DW(W + 1), .SIDE_W(3)) u_div_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (v_s3),
		.src_num   (n1m_s3),
		.src_den   (den_s3),
		.src_side  ({kind_s3, neg1_s3}),
		.res_valid (v_d1),
		.res_quot  (q1),
		.res_side  (side_d1)
	);

	qrs_div #(.NW(NW), .DW(W + 1), .SIDE_W(1)) u_div_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (v_s3),
		.src_num   (n2m_s3),
		.src_den   (den_s3),
		.src_side  (neg2_s3),
		.res_valid (v_d2),
		.res_quot  (q2),
		.res_side  (side_d2)
	);

	function automatic logic [OUT_WIDTH-1:0] fix_out(input logic [NW-1:0] q, input logic neg);
		logic signed [VW-1:0] v;
		logic signed [VW-1:0] hi;
		logic signed [VW-1:0] lo;
		v  = signed'(VW'(q));
		hi = signed'({{(VW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}});
		lo = ~hi;
		if (neg) begin
			v = -v;
		end
		if (v > hi) begin
			v = hi;
		end else if (v < lo) begin
			v = lo;
		end
		return v[OUT_WIDTH-1:0];
	endfunction

	kind_t kind_d;
	assign kind_d = kind_t'(side_d1[2:1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_kind <= kind_d;
			if (kind_d == KIND_INVALID) begin
				first_value  <= '0;
				second_value <= '0;
			end else begin
				first_value  <= fix_out(q1, side_d1[0]);
				second_value <= fix_out(q2, side_d2);
			end
		end
	end

	`QRS_ASSERT_NOW(a_div_lockstep, v_d1 || v_d2, v_d1 && v_d2, "dividers out of step")
	`QRS_ASSERT_NOW(a_invalid_zero, out_valid && root_kind == KIND_INVALID, first_value == '0 && second_value == '0, "invalid kind with nonzero values")
	`QRS_ASSERT_NOW(a_repeated_same, out_valid && root_kind == KIND_REPEATED, first_value == second_value, "repeated root values differ")
	`QRS_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(first_value) && $stable(second_value), "stalled result changed")
endmodule
